[rtl/tpte_pkg.sv]
`timescale 1ns / 1ps
package tpte_pkg;

  // Register map, selected by paddr[2]
  localparam int PADDR_W = 3;
  localparam logic REG_PLANE_X = 1'b0;
  localparam logic REG_MIN_DX  = 1'b1;

  localparam logic signed [31:0] PLANE_X_RST = -32'sd32768;
  localparam logic [30:0]        MIN_DX_RST  = 31'd1;

  // Detector element ranges
  localparam logic [8:0] CN_RF_LO = 9'd0;
  localparam logic [8:0] CN_RF_HI = 9'd12;
  localparam logic [8:0] CN_RB_LO = 9'd100;
  localparam logic [8:0] CN_RB_HI = 9'd112;
  localparam logic [8:0] CN_LF_LO = 9'd200;
  localparam logic [8:0] CN_LF_HI = 9'd212;
  localparam logic [8:0] CN_LB_LO = 9'd300;
  localparam logic [8:0] CN_LB_HI = 9'd312;

  // Hit slots per event
  localparam int         NUM_SLOTS = 4;
  localparam logic [1:0] SLOT_LF   = 2'd0;
  localparam logic [1:0] SLOT_LB   = 2'd1;
  localparam logic [1:0] SLOT_RF   = 2'd2;
  localparam logic [1:0] SLOT_RB   = 2'd3;

  // Divider geometry
  localparam int DVD_W = 64;
  localparam int DVS_W = 32;

  // Quotients above this saturate outright
  localparam logic [63:0] Q_SAT_LIM = 64'h0000_0002_0000_0000;

  typedef struct packed {
    logic rec;
    logic pick;
    logic delta;
    logic mul;
    logic div_go;
    logic round;
    logic sum;
    logic load_out;
    logic coord;
  } cmd_t;

  typedef struct packed {
    logic pair_ok;
    logic dx_ok;
    logic div_done;
  } stat_t;

endpackage

[rtl/two_plane_track_extrapolator.sv]
`timescale 1ns / 1ps
// Two-plane track extrapolator. Hits of one event stream in on the input
// channel; each side keeps its first front and first back hit. The hit with
// last_hit set closes the event: the side whose front arrived first is
// paired, and the straight line through front and back is projected to the
// plane x = plane_x (register 0), giving y and z rounded to nearest and
// saturated, with clipped set on saturation. No result comes out when no
// side has both hits or |dx| is zero or below min_dx (register 1).
// Ordinary hits are taken one per cycle. The closing hit stalls the input
// while the shared 64-step divider runs once for y and once for z; a
// finished result waits in the output register while the next event's hits
// are taken, and stretches the next close only if it is still waiting
// then. Up to MAX_HITS hits per event are recorded.
module two_plane_track_extrapolator #(
  parameter int MAX_HITS = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  // hit requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [31:0]                  event_id,
  input  logic [8:0]                   copy_number,
  input  logic signed [31:0]           hit_x,
  input  logic signed [31:0]           hit_y,
  input  logic signed [31:0]           hit_z,
  input  logic                         last_hit,
  // result requests
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  out_event_id,
  output logic signed [31:0]           proj_y,
  output logic signed [31:0]           proj_z,
  output logic                         pair_side,
  output logic                         clipped,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpte_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tpte_pkg::*;

  logic signed [31:0] plane_x;
  logic [30:0]        min_dx;
  logic               cfg_wr;
  cmd_t               cmd;
  stat_t              stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_x <= PLANE_X_RST;
      min_dx  <= MIN_DX_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PLANE_X: plane_x <= pwdata;
        REG_MIN_DX:  min_dx  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[2])
      REG_PLANE_X: prdata = plane_x;
      REG_MIN_DX:  prdata = {1'b0, min_dx};
      default:     prdata = '0;
    endcase
  end

  tpte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_hit  (last_hit),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tpte_dp #(
    .MAX_HITS (MAX_HITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .plane_x      (plane_x),
    .min_dx       (min_dx),
    .event_id     (event_id),
    .copy_number  (copy_number),
    .hit_x        (hit_x),
    .hit_y        (hit_y),
    .hit_z        (hit_z),
    .last_hit     (last_hit),
    .out_event_id (out_event_id),
    .proj_y       (proj_y),
    .proj_z       (proj_z),
    .pair_side    (pair_side),
    .clipped      (clipped)
  );

endmodule

[rtl/tpte_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module tpte_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tpte_pkg::DVD_W-1:0] dividend,
  input  logic [tpte_pkg::DVS_W-1:0] divisor,
  output logic [tpte_pkg::DVD_W-1:0] quotient,
  output logic [tpte_pkg::DVS_W-1:0] remainder,
  output logic                       done
);
  import tpte_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= CNT_W'(DVD_W - 1);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift quotient bits in, keep remainder below divisor
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[rtl/tpte_dp.sv]
`timescale 1ns / 1ps
module tpte_dp #(
  parameter int MAX_HITS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  tpte_pkg::cmd_t      cmd,
  output tpte_pkg::stat_t     stat,
  input  logic signed [31:0]  plane_x,
  input  logic [30:0]         min_dx,
  input  logic [31:0]         event_id,
  input  logic [8:0]          copy_number,
  input  logic signed [31:0]  hit_x,
  input  logic signed [31:0]  hit_y,
  input  logic signed [31:0]  hit_z,
  input  logic                last_hit,
  output logic [31:0]         out_event_id,
  output logic signed [31:0]  proj_y,
  output logic signed [31:0]  proj_z,
  output logic                pair_side,
  output logic                clipped
);
  import tpte_pkg::*;

  localparam int IDX_W = $clog2(MAX_HITS + 1);
  localparam int ORD_W = $clog2(MAX_HITS);

  localparam logic signed [35:0] S_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] S_MIN = 36'shF_8000_0000;
  localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] P_MIN = 32'sh8000_0000;

  function automatic logic [2:0] classify(input logic [8:0] cn);
    logic [2:0] code;
    code = {1'b0, SLOT_LF};
    if (cn inside {[CN_RF_LO:CN_RF_HI]})      code = {1'b1, SLOT_RF};
    else if (cn inside {[CN_RB_LO:CN_RB_HI]}) code = {1'b1, SLOT_RB};
    else if (cn inside {[CN_LF_LO:CN_LF_HI]}) code = {1'b1, SLOT_LF};
    else if (cn inside {[CN_LB_LO:CN_LB_HI]}) code = {1'b1, SLOT_LB};
    return code;
  endfunction

  // Event slots
  logic [NUM_SLOTS-1:0]     slot_seen;
  logic [ORD_W-1:0]         slot_order [NUM_SLOTS];
  logic signed [31:0]       slot_x     [NUM_SLOTS];
  logic signed [31:0]       slot_y     [NUM_SLOTS];
  logic signed [31:0]       slot_z     [NUM_SLOTS];
  logic [IDX_W-1:0]         hit_index;
  logic [31:0]              close_id;

  logic [2:0]               hit_cls;
  logic [1:0]               cls_slot;
  logic                     room;
  logic                     take_hit;

  // Pair selection
  logic                     left_ok;
  logic                     right_ok;
  logic                     pick_right;
  logic [1:0]               front_sel;
  logic [1:0]               back_sel;
  logic [32:0]              xf33;
  logic [32:0]              xb33;
  logic [32:0]              px33;
  logic [32:0]              dx_fwd;
  logic [32:0]              dx_rev;
  logic [32:0]              nm_fwd;
  logic [32:0]              nm_rev;

  // Working registers
  logic                     side_r;
  logic                     dx_neg;
  logic [31:0]              dx_mag;
  logic                     num_neg;
  logic [31:0]              num_mag;
  logic signed [31:0]       fy;
  logic signed [31:0]       by;
  logic signed [31:0]       fz;
  logic signed [31:0]       bz;
  logic signed [31:0]       base;
  logic                     prod_neg;
  logic [31:0]              dl_mag;
  logic [63:0]              prod;
  logic [63:0]              q_rnd;
  logic signed [31:0]       res_y;
  logic signed [31:0]       res_z;
  logic                     clip_acc;

  logic signed [31:0]       p_f;
  logic signed [31:0]       p_b;
  logic [32:0]              dl_fwd;
  logic [32:0]              dl_rev;

  logic [DVD_W-1:0]         div_q;
  logic [DVS_W-1:0]         div_r;
  logic                     div_done;

  logic                     q_big;
  logic [35:0]              base36;
  logic [35:0]              q36;
  logic signed [35:0]       s_val;
  logic signed [31:0]       sum_val;
  logic                     sum_clip;

  // Classify the incoming hit
  always_comb begin
    hit_cls  = classify(copy_number);
    cls_slot = hit_cls[1:0];
    room     = (hit_index < IDX_W'(MAX_HITS));
    take_hit = cmd.rec && room && hit_cls[2] && !slot_seen[cls_slot];
  end

  // Slot flags and arrival counter; clear when the event closes
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_seen <= '0;
      hit_index <= '0;
    end else if (cmd.pick) begin
      slot_seen <= '0;
      hit_index <= '0;
    end else if (cmd.rec && room) begin
      hit_index <= hit_index + 1'b1;
      if (take_hit) slot_seen[cls_slot] <= 1'b1;
    end
  end

  // Record first hit of each element class
  always_ff @(posedge clk) begin
    if (take_hit) begin
      slot_order[cls_slot] <= hit_index[ORD_W-1:0];
      slot_x[cls_slot]     <= hit_x;
      slot_y[cls_slot]     <= hit_y;
      slot_z[cls_slot]     <= hit_z;
    end
    if (cmd.rec && last_hit) close_id <= event_id;
  end

  // Choose the side whose front came first, form dx and plane offset
  always_comb begin
    left_ok    = slot_seen[SLOT_LF] & slot_seen[SLOT_LB];
    right_ok   = slot_seen[SLOT_RF] & slot_seen[SLOT_RB];
    pick_right = right_ok && (!left_ok || (slot_order[SLOT_RF] < slot_order[SLOT_LF]));
    front_sel  = pick_right ? SLOT_RF : SLOT_LF;
    back_sel   = pick_right ? SLOT_RB : SLOT_LB;
    xf33       = {slot_x[front_sel][31], slot_x[front_sel]};
    xb33       = {slot_x[back_sel][31], slot_x[back_sel]};
    px33       = {plane_x[31], plane_x};
    dx_fwd     = xb33 - xf33;
    dx_rev     = xf33 - xb33;
    nm_fwd     = px33 - xf33;
    nm_rev     = xf33 - px33;
  end

  // Per-coordinate difference between back and front
  always_comb begin
    p_f    = cmd.coord ? fz : fy;
    p_b    = cmd.coord ? bz : by;
    dl_fwd = {p_b[31], p_b} - {p_f[31], p_f};
    dl_rev = {p_f[31], p_f} - {p_b[31], p_b};
  end

  // Add the rounded quotient to the front coordinate and saturate
  always_comb begin
    q_big    = (q_rnd > Q_SAT_LIM);
    base36   = {{4{base[31]}}, base};
    q36      = {2'b00, q_rnd[33:0]};
    s_val    = prod_neg ? (base36 - q36) : (base36 + q36);
    sum_clip = 1'b1;
    if (q_big) begin
      sum_val = prod_neg ? P_MIN : P_MAX;
    end else if (s_val > S_MAX) begin
      sum_val = P_MAX;
    end else if (s_val < S_MIN) begin
      sum_val = P_MIN;
    end else begin
      sum_val  = s_val[31:0];
      sum_clip = 1'b0;
    end
  end

  // Datapath registers, stepped by the controller
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      side_r   <= pick_right;
      dx_neg   <= dx_fwd[32];
      dx_mag   <= dx_fwd[32] ? dx_rev[31:0] : dx_fwd[31:0];
      num_neg  <= nm_fwd[32];
      num_mag  <= nm_fwd[32] ? nm_rev[31:0] : nm_fwd[31:0];
      fy       <= slot_y[front_sel];
      by       <= slot_y[back_sel];
      fz       <= slot_z[front_sel];
      bz       <= slot_z[back_sel];
      clip_acc <= 1'b0;
    end
    if (cmd.delta) begin
      base     <= p_f;
      dl_mag   <= dl_fwd[32] ? dl_rev[31:0] : dl_fwd[31:0];
      prod_neg <= num_neg ^ dl_fwd[32] ^ dx_neg;
    end
    if (cmd.mul) begin
      prod <= num_mag * dl_mag;
    end
    if (cmd.round) begin
      q_rnd <= div_q + 64'({div_r, 1'b0} >= {1'b0, dx_mag});
    end
    if (cmd.sum) begin
      if (cmd.coord) res_z <= sum_val;
      else           res_y <= sum_val;
      clip_acc <= clip_acc | sum_clip;
    end
    if (cmd.load_out) begin
      out_event_id <= close_id;
      proj_y       <= res_y;
      proj_z       <= res_z;
      pair_side    <= side_r;
      clipped      <= clip_acc;
    end
  end

  tpte_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_go),
    .dividend  (prod),
    .divisor   (dx_mag),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  // Status back to the controller
  always_comb begin
    stat.pair_ok  = left_ok | right_ok;
    stat.dx_ok    = (dx_mag != '0) && (dx_mag >= {1'b0, min_dx});
    stat.div_done = div_done;
  end

endmodule

[rtl/tpte_ctrl.sv]
`timescale 1ns / 1ps
module tpte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            last_hit,
  input  logic            out_stall,
  input  tpte_pkg::stat_t stat,
  output logic            in_stall,
  output logic            out_valid,
  output tpte_pkg::cmd_t  cmd
);
  import tpte_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_PICK  = 10'b00_0000_0010,
    S_CHECK = 10'b00_0000_0100,
    S_DELTA = 10'b00_0000_1000,
    S_MUL   = 10'b00_0001_0000,
    S_DIVGO = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_ROUND = 10'b00_1000_0000,
    S_SUM   = 10'b01_0000_0000,
    S_PUSH  = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   coord;
  logic   coord_next;
  logic   out_valid_next;
  logic   in_acc;
  logic   out_free;

  // Handshakes and commands
  always_comb begin
    in_stall     = (state != S_IDLE);
    in_acc       = in_valid && !in_stall;
    out_free     = !out_valid || !out_stall;
    cmd          = '0;
    cmd.rec      = in_acc;
    cmd.pick     = (state == S_PICK);
    cmd.delta    = (state == S_DELTA);
    cmd.mul      = (state == S_MUL);
    cmd.div_go   = (state == S_DIVGO);
    cmd.round    = (state == S_ROUND);
    cmd.sum      = (state == S_SUM);
    cmd.load_out = (state == S_PUSH) && out_free;
    cmd.coord    = coord;
  end

  // Sequence: pick pair, check spacing, y then z through the divider, push
  always_comb begin
    state_next = state;
    coord_next = coord;
    case (state)
      S_IDLE: begin
        if (in_acc && last_hit) state_next = S_PICK;
      end
      S_PICK: begin
        state_next = stat.pair_ok ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        coord_next = 1'b0;
        state_next = stat.dx_ok ? S_DELTA : S_IDLE;
      end
      S_DELTA: state_next = S_MUL;
      S_MUL:   state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIV;
      S_DIV: begin
        if (stat.div_done) state_next = S_ROUND;
      end
      S_ROUND: state_next = S_SUM;
      S_SUM: begin
        if (coord) begin
          state_next = S_PUSH;
        end else begin
          coord_next = 1'b1;
          state_next = S_DELTA;
        end
      end
      S_PUSH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out)               out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      coord     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      coord     <= coord_next;
      out_valid <= out_valid_next;
    end
  end

  a_close_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last_hit) |=> (state == S_PICK && in_stall))
    else $error("closing request did not start event evaluation");

  a_push_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && out_valid && out_stall) |=> (state == S_PUSH && out_valid))
    else $error("pending result overwritten");

  a_out_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_PUSH))
    else $error("result raised outside push");

endmodule
